[design/mudc_pkg.sv]
package mudc_pkg;

   localparam int COUNT_W   = 6;
   localparam int WINDOW_W  = 8;
   localparam int SEG_W     = 7;
   localparam int DIGIT_W   = 4;
   localparam int CSR_IDX_W = 1;

   // one bit wider than the count so the up-step carry is visible
   localparam logic [COUNT_W:0]   MODULUS     = 7'd60;
   localparam logic [COUNT_W-1:0] UP_CLEAR    = 6'd25;
   localparam logic [COUNT_W-1:0] DOWN_CLEAR  = 6'd50;

   localparam logic [WINDOW_W-1:0] UP_WINDOW_RESET   = 8'd20;
   localparam logic [WINDOW_W-1:0] DOWN_WINDOW_RESET = 8'd50;

   localparam logic [CSR_IDX_W-1:0] REG_UP_WINDOW   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN_WINDOW = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0] count_value;
      logic [SEG_W-1:0]   segments;
      logic               high_digit_selected;
      logic               led_on;
   } rsp_type;

   // tens digit of a 6-bit value, by compare against the multiples of ten
   function automatic logic [DIGIT_W-1:0] tens_of(input logic [COUNT_W-1:0] v);
      logic [DIGIT_W-1:0] t;
      t = '0;
      for (int k = 1; k <= 6; k++) begin
         if (v >= COUNT_W'(k * 10)) t = DIGIT_W'(k);
      end
      return t;
   endfunction

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         default: s = 7'h6F;  // nine, and anything above clamps to it
      endcase
      return s;
   endfunction

endpackage

[design/mod60_up_down_display_counter.sv]
// Modulo-60 up/down counter with a multiplexed two-digit seven-segment output
// and a wrap LED. Each req beat is one tick carrying the direction switch; each
// tick yields exactly one rsp beat with the count before the update, the
// segment pattern of the units or tens digit (alternating, units first), the
// digit select and the LED level after the tick. One tick is taken every cycle
// while req_stall is low: the tick logic sits between the state registers and
// a result register, and a one-entry skid register behind it lets req keep
// flowing for one beat while rsp is stalled; req_stall comes from a register.
// Results enter the result register, or the skid while rsp stalls. Window
// length writes on csr take effect next window; csr_ready is always high.
module mod60_up_down_display_counter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_count_up,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mudc_pkg::COUNT_W-1:0]      rsp_count_value,
   output logic [mudc_pkg::SEG_W-1:0]        rsp_segments,
   output logic                              rsp_high_digit_selected,
   output logic                              rsp_led_on,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mudc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mudc_pkg::WINDOW_W-1:0]     csr_wdata
);
   import mudc_pkg::*;

   logic [WINDOW_W-1:0] up_win_ff,   up_win_in;
   logic [WINDOW_W-1:0] down_win_ff, down_win_in;
   logic [COUNT_W-1:0]  count_ff,    count_in;
   logic [WINDOW_W-1:0] tick_ff,     tick_in;
   logic [WINDOW_W-1:0] win_len_ff,  win_len_in;
   logic                show_hi_ff,  show_hi_in;
   logic                led_ff,      led_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   rsp_type             rsp_ff, rsp_in;
   rsp_type             skid_ff, skid_in;

   logic                accept;
   logic                out_take;
   logic [WINDOW_W-1:0] win_eff;
   logic [WINDOW_W-1:0] tick_next;
   logic                win_end;
   logic [COUNT_W:0]    count_inc;
   logic [COUNT_W-1:0]  count_dec;
   logic [SEG_W-1:0]    seg;
   rsp_type             result;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = rsp_valid_ff && !rsp_stall;

   mudc_seg_decode u_seg (
      .count      (count_ff),
      .high_digit (show_hi_ff),
      .segments   (seg)
   );

   always_comb begin
      up_win_in   = up_win_ff;
      down_win_in = down_win_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_UP_WINDOW:   up_win_in   = csr_wdata;
            REG_DOWN_WINDOW: down_win_in = csr_wdata;
            default:         ;
         endcase
      end
   end

   always_comb begin
      count_in   = count_ff;
      tick_in    = tick_ff;
      win_len_in = win_len_ff;
      show_hi_in = show_hi_ff;
      led_in     = led_ff;

      // first tick of a window latches its length
      win_eff   = (tick_ff == '0) ? (req_count_up ? up_win_ff : down_win_ff) : win_len_ff;
      tick_next = tick_ff + 1'b1;
      // a zero length behaves as one; an 8-bit rollover also ends the window
      win_end   = (tick_next >= win_eff) || (tick_next == '0);
      count_inc = {1'b0, count_ff} + 1'b1;
      count_dec = (count_ff == '0) ? COUNT_W'(MODULUS - 1'b1) : count_ff - 1'b1;

      if (accept) begin
         win_len_in = win_eff;
         show_hi_in = !show_hi_ff;
         tick_in    = win_end ? '0 : tick_next;
         if (win_end) begin
            if (req_count_up) begin
               if (count_inc == {1'b0, UP_CLEAR}) led_in = 1'b0;
               if (count_inc >= MODULUS) begin
                  count_in = '0;
                  led_in   = 1'b1;
               end else begin
                  count_in = count_inc[COUNT_W-1:0];
               end
            end else begin
               if (count_ff == '0) led_in = 1'b1;
               if (count_dec == DOWN_CLEAR) led_in = 1'b0;
               count_in = count_dec;
            end
         end
      end

      result.count_value         = count_ff;
      result.segments            = seg;
      result.high_digit_selected = show_hi_ff;
      result.led_on              = led_in;
   end

   // output register with a one-beat skid behind it
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_win_ff     <= UP_WINDOW_RESET;
         down_win_ff   <= DOWN_WINDOW_RESET;
         count_ff      <= '0;
         tick_ff       <= '0;
         win_len_ff    <= '0;
         show_hi_ff    <= 1'b0;
         led_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         up_win_ff     <= up_win_in;
         down_win_ff   <= down_win_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
         win_len_ff    <= win_len_in;
         show_hi_ff    <= show_hi_in;
         led_ff        <= led_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_count_value         = rsp_ff.count_value;
   assign rsp_segments            = rsp_ff.segments;
   assign rsp_high_digit_selected = rsp_ff.high_digit_selected;
   assign rsp_led_on              = rsp_ff.led_on;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} < MODULUS)
      else $error("count out of range");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_tick_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(tick_ff) && $stable(count_ff))
      else $error("tick state moved without an accepted beat");

   a_digit_toggles: assert property (@(posedge clock) disable iff (reset)
      accept |=> show_hi_ff != $past(show_hi_ff))
      else $error("digit select did not alternate");
`endif

endmodule

[design/mudc_seg_decode.sv]
module mudc_seg_decode (
   input  logic [mudc_pkg::COUNT_W-1:0] count,
   input  logic                         high_digit,
   output logic [mudc_pkg::SEG_W-1:0]   segments
);
   import mudc_pkg::*;

   logic [DIGIT_W-1:0] tens;
   logic [COUNT_W-1:0] units_full;
   logic [DIGIT_W-1:0] digit;

   always_comb begin
      tens       = tens_of(count);
      units_full = count - COUNT_W'(tens) * COUNT_W'(10);
      digit      = high_digit ? tens : units_full[DIGIT_W-1:0];
      segments   = seg_pattern(digit);
   end

endmodule
